// ----- rtl/esc_pkg.sv -----
// esc_pkg: shared types, constants and helper functions for the
// seconds-to-calendar converter. no dependencies.
package esc_pkg;

  localparam logic [31:0] MIN_SECS       = 32'd60;
  localparam logic [31:0] HOUR_SECS      = 32'd3600;
  localparam logic [31:0] DAY_SECS       = 32'd86400;
  localparam logic [31:0] YEAR_SECS      = 32'd31536000;  // 365 days
  localparam logic [31:0] YEAR_LEAP_SECS = 32'd31622400;  // 366 days

  localparam logic [7:0] BASE_YEAR   = 8'd90;   // 1990 - 1900
  localparam logic [1:0] LEAP_PHASE  = 2'd2;    // offset mod 4 of a leap year
  localparam logic [2:0] WD_EPOCH    = 3'd1;    // 1990-01-01 was a monday
  localparam logic [3:0] MONTH_FEB   = 4'd1;
  localparam logic [3:0] MONTH_DEC   = 4'd11;

  // top quotient bit index of the restoring divisions
  localparam logic [3:0] DAY_TOP  = 4'd8;   // day of year < 512
  localparam logic [3:0] HOUR_TOP = 4'd4;   // hour < 32
  localparam logic [3:0] MIN_TOP  = 4'd5;   // minute < 64

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_DAY,
    ST_MONTH,
    ST_HOUR,
    ST_MIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] diff;
    logic        ge;
  } alu_rsp_t;

  typedef struct packed {
    logic [7:0] year_since_1900;
    logic [3:0] month;
    logic [4:0] day_of_month;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
    logic [8:0] day_of_year;
  } cal_t;

  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    logic [4:0] d;
    case (mon)
      4'd0:  d = 5'd31;
      4'd1:  d = leap ? 5'd29 : 5'd28;
      4'd2:  d = 5'd31;
      4'd3:  d = 5'd30;
      4'd4:  d = 5'd31;
      4'd5:  d = 5'd30;
      4'd6:  d = 5'd31;
      4'd7:  d = 5'd31;
      4'd8:  d = 5'd30;
      4'd9:  d = 5'd31;
      4'd10: d = 5'd30;
      4'd11: d = 5'd31;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

  // sum of two residues mod 7
  function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[2:0];
  endfunction

  // 2**k mod 7 for a quotient bit of the day division
  function automatic logic [2:0] pow2_mod7(input logic [3:0] k);
    logic [2:0] r;
    case (k)
      4'd0, 4'd3, 4'd6: r = 3'd1;
      4'd1, 4'd4, 4'd7: r = 3'd2;
      4'd2, 4'd5, 4'd8: r = 3'd4;
      default:          r = 3'd1;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/esc_in_if.sv -----
// esc_in_if: valid/ready channel carrying one seconds count.
// depends on nothing.
interface esc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] seconds;

  modport source (output valid, output seconds, input ready);
  modport sink   (input valid, input seconds, output ready);
endinterface

// ----- rtl/esc_out_if.sv -----
// esc_out_if: valid/ready channel carrying one calendar result.
// depends on nothing.
interface esc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] year_since_1900;
  logic [3:0] month;
  logic [4:0] day_of_month;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;
  logic [2:0] weekday;
  logic [8:0] day_of_year;

  modport source (output valid, output year_since_1900, output month,
                  output day_of_month, output hour, output minute, output second,
                  output weekday, output day_of_year, input ready);
  modport sink   (input valid, input year_since_1900, input month,
                  input day_of_month, input hour, input minute, input second,
                  input weekday, input day_of_year, output ready);
endinterface

// ----- rtl/esc_alu.sv -----
// esc_alu: the shared 32-bit compare-and-subtract unit.
// depends on esc_pkg.
module esc_alu import esc_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [32:0] wide;

  assign wide     = {1'b0, req.a} - {1'b0, req.b};
  assign rsp.diff = wide[31:0];
  assign rsp.ge   = ~wide[32];

endmodule

// ----- rtl/esc_core.sv -----
// esc_core: sequencer that drives the shared subtractor through the year,
// day, month, hour and minute steps. depends on esc_pkg and esc_alu.
module esc_core import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] seconds,
  input  logic        taken,
  output logic        idle,
  output logic        done,
  output cal_t        result
);

  state_t      state, state_next;
  logic [31:0] rem, rem_next;
  logic [7:0]  yoff, yoff_next;
  logic [3:0]  k, k_next;
  logic [8:0]  yday, yday_next;
  logic [3:0]  mon, mon_next;
  logic [8:0]  dleft, dleft_next;
  logic [4:0]  hour, hour_next;
  logic [5:0]  minute, minute_next;
  logic [2:0]  wd, wd_next;
  logic        leap;
  alu_req_t    req;
  alu_rsp_t    rsp;

  esc_alu u_alu (
    .req (req),
    .rsp (rsp)
  );

  assign leap = (yoff[1:0] == LEAP_PHASE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    rem    <= rem_next;
    yoff   <= yoff_next;
    k      <= k_next;
    yday   <= yday_next;
    mon    <= mon_next;
    dleft  <= dleft_next;
    hour   <= hour_next;
    minute <= minute_next;
    wd     <= wd_next;
  end

  always_comb begin
    state_next  = state;
    rem_next    = rem;
    yoff_next   = yoff;
    k_next      = k;
    yday_next   = yday;
    mon_next    = mon;
    dleft_next  = dleft;
    hour_next   = hour;
    minute_next = minute;
    wd_next     = wd;
    req.a       = rem;
    req.b       = 32'd0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          rem_next   = seconds;
          yoff_next  = 8'd0;
          wd_next    = WD_EPOCH;
          state_next = ST_YEAR;
        end
      end
      ST_YEAR: begin
        req.b = leap ? YEAR_LEAP_SECS : YEAR_SECS;
        if (rsp.ge) begin
          rem_next  = rsp.diff;
          yoff_next = yoff + 8'd1;
          wd_next   = add_mod7(wd, leap ? 3'd2 : 3'd1);
        end else begin
          k_next     = DAY_TOP;
          yday_next  = 9'd0;
          state_next = ST_DAY;
        end
      end
      ST_DAY: begin
        req.b     = DAY_SECS << k;
        yday_next = {yday[7:0], rsp.ge};
        if (rsp.ge) begin
          rem_next = rsp.diff;
          wd_next  = add_mod7(wd, pow2_mod7(k));
        end
        if (k == 4'd0) begin
          mon_next   = 4'd0;
          dleft_next = {yday[7:0], rsp.ge};
          state_next = ST_MONTH;
        end else begin
          k_next = k - 4'd1;
        end
      end
      ST_MONTH: begin
        req.a = {23'd0, dleft};
        req.b = {27'd0, month_days(mon, leap)};
        if (rsp.ge && (mon != MONTH_DEC)) begin
          dleft_next = rsp.diff[8:0];
          mon_next   = mon + 4'd1;
        end else begin
          k_next     = HOUR_TOP;
          hour_next  = 5'd0;
          state_next = ST_HOUR;
        end
      end
      ST_HOUR: begin
        req.b     = HOUR_SECS << k;
        hour_next = {hour[3:0], rsp.ge};
        if (rsp.ge) begin
          rem_next = rsp.diff;
        end
        if (k == 4'd0) begin
          k_next      = MIN_TOP;
          minute_next = 6'd0;
          state_next  = ST_MIN;
        end else begin
          k_next = k - 4'd1;
        end
      end
      ST_MIN: begin
        req.b       = MIN_SECS << k;
        minute_next = {minute[4:0], rsp.ge};
        if (rsp.ge) begin
          rem_next = rsp.diff;
        end
        if (k == 4'd0) begin
          state_next = ST_DONE;
        end else begin
          k_next = k - 4'd1;
        end
      end
      ST_DONE: begin
        if (taken) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign idle = (state == ST_IDLE);
  assign done = (state == ST_DONE);

  assign result.year_since_1900 = yoff + BASE_YEAR;
  assign result.month           = mon;
  assign result.day_of_month    = dleft[4:0] + 5'd1;
  assign result.hour            = hour;
  assign result.minute          = minute;
  assign result.second          = rem[5:0];
  assign result.weekday         = wd;
  assign result.day_of_year     = yday;

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MONTH) |-> (mon <= MONTH_DEC))
    else $error("month index ran past december");

  a_day_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOUR) |-> (rem < DAY_SECS))
    else $error("remainder not below one day at hour step");

  a_hour_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MIN) |-> (rem < HOUR_SECS))
    else $error("remainder not below one hour at minute step");

  a_done_fields: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> ((wd < 3'd7) && (rem < MIN_SECS) && (hour < 5'd24)
                            && (dleft < 9'd31)))
    else $error("calendar fields out of range at completion");

endmodule

// ----- rtl/epoch_seconds_to_calendar.sv -----
// epoch_seconds_to_calendar: top level, seconds since 1990-01-01 gmt to
// calendar fields. depends on esc_pkg, esc_in_if, esc_out_if and esc_core.
//
//  channel    dir  payload                                   handshake
//  stamp      in   seconds[31:0]                             valid/ready
//  calendar   out  year_since_1900, month, day_of_month,     valid/ready
//                  hour, minute, second, weekday, day_of_year
//
// a transaction takes off Y whole years (0..136), divides out the day of year,
// takes off M months (0..11) and divides out hour and minute; the shared
// subtractor in esc_core does one compare-subtract a cycle
// stamp.ready is high only while the sequencer is idle, so the next stamp
// is taken in the cycle after the result leaves the sequencer
// a finished result moves to the output register, so a new stamp can be
// taken while calendar is stalled
// rst is synchronous and clears the sequencer and the output valid
module epoch_seconds_to_calendar import esc_pkg::*; (
  input logic      clk,
  input logic      rst,
  esc_in_if.sink   stamp,
  esc_out_if.source calendar
);

  logic core_idle;
  logic core_done;
  logic take;
  logic out_valid;
  cal_t core_result;
  cal_t out_reg;

  // core result moves out when the output register is free or draining
  assign take = core_done && (!out_valid || calendar.ready);

  esc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .start   (stamp.valid),
    .seconds (stamp.seconds),
    .taken   (take),
    .idle    (core_idle),
    .done    (core_done),
    .result  (core_result)
  );

  assign stamp.ready = core_idle;

  // output register: valid bit under reset, payload without
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (calendar.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_reg <= core_result;
    end
  end

  assign calendar.valid           = out_valid;
  assign calendar.year_since_1900 = out_reg.year_since_1900;
  assign calendar.month           = out_reg.month;
  assign calendar.day_of_month    = out_reg.day_of_month;
  assign calendar.hour            = out_reg.hour;
  assign calendar.minute          = out_reg.minute;
  assign calendar.second          = out_reg.second;
  assign calendar.weekday         = out_reg.weekday;
  assign calendar.day_of_year     = out_reg.day_of_year;

endmodule

// ----- verif/tb_top.sv -----
// tb_top: self-checking testbench for epoch_seconds_to_calendar
// holds a scoreboard with its own calendar predictor, plus valid/ready drivers
// depends on esc_pkg, esc_in_if, esc_out_if and the rtl of the block
`timescale 1ns / 1ps

module tb_top;
  import esc_pkg::*;

  // cycle budget for the whole run
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  // pause after the results are back; covers the longest accept-to-result path of 136 years and 11 months taken off
  localparam int unsigned DRAIN_CYCLES = 200;
  // receiver hold-off used to back the block up into its input channel
  localparam int unsigned LONG_HOLD    = 600;
  localparam int unsigned LAST_YEAR    = 136;  // 2126 is the last year a 32-bit count reaches

  // ------------------------------------------------------------------
  // scoreboard: converts each accepted stamp and checks results in order
  // ------------------------------------------------------------------
  typedef struct {
    logic [31:0] secs;
    cal_t        cal;
  } pending_date_t;

  class calendar_scoreboard;
    pending_date_t dates_q[$];
    int unsigned   n_stamps;
    int unsigned   n_checked;
    int unsigned   n_errors;
    int unsigned   min_year;
    int unsigned   max_year;

    function new();
      min_year = 255;
      max_year = 0;
    endfunction

    // breaks a seconds count down into the calendar fields
    function cal_t to_calendar(logic [31:0] secs);
      int unsigned len_tab[12];
      cal_t        c;
      logic [31:0] rest;
      logic [31:0] span;
      int unsigned years;
      int unsigned mon;
      int unsigned dim;
      bit          leap;
      len_tab = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      rest  = secs;
      years = 0;
      // peel whole years off, leap when offset mod 4 hits the leap phase
      forever begin
        leap = (years[1:0] == LEAP_PHASE);
        span = leap ? YEAR_LEAP_SECS : YEAR_SECS;
        if (rest < span) break;
        rest -= span;
        years++;
      end
      c.year_since_1900 = BASE_YEAR + years[7:0];
      c.day_of_year     = 9'(rest / DAY_SECS);
      // then whole months, stopping at december
      mon = 0;
      forever begin
        dim = (mon == MONTH_FEB && leap) ? 29 : len_tab[mon];
        if (rest < dim * DAY_SECS || mon >= MONTH_DEC) break;
        rest -= dim * DAY_SECS;
        mon++;
      end
      c.month        = mon[3:0];
      c.day_of_month = 5'(rest / DAY_SECS + 1);
      rest           = rest % DAY_SECS;
      c.hour         = 5'(rest / HOUR_SECS);
      rest           = rest % HOUR_SECS;
      c.minute       = 6'(rest / MIN_SECS);
      c.second       = 6'(rest % MIN_SECS);
      c.weekday      = 3'((secs / DAY_SECS + WD_EPOCH) % 7);
      return c;
    endfunction

    function void note_stamp(logic [31:0] secs);
      pending_date_t p;
      p.secs = secs;
      p.cal  = to_calendar(secs);
      dates_q.push_back(p);
      n_stamps++;
    endfunction

    function void check_field(string name, logic [31:0] secs, int unsigned want,
                              int unsigned got);
      if (want != got) begin
        $error("%s mismatch for %0d s: expected %0d, actual %0d", name, secs, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(cal_t got);
      pending_date_t p;
      if (dates_q.size() == 0) begin
        $error("calendar result with no stamp outstanding: year %0d month %0d day %0d",
               got.year_since_1900, got.month, got.day_of_month);
        n_errors++;
        return;
      end
      p = dates_q.pop_front();
      n_checked++;
      if (p.cal.year_since_1900 < min_year) min_year = p.cal.year_since_1900;
      if (p.cal.year_since_1900 > max_year) max_year = p.cal.year_since_1900;
      check_field("year_since_1900", p.secs, p.cal.year_since_1900, got.year_since_1900);
      check_field("month", p.secs, p.cal.month, got.month);
      check_field("day_of_month", p.secs, p.cal.day_of_month, got.day_of_month);
      check_field("hour", p.secs, p.cal.hour, got.hour);
      check_field("minute", p.secs, p.cal.minute, got.minute);
      check_field("second", p.secs, p.cal.second, got.second);
      check_field("weekday", p.secs, p.cal.weekday, got.weekday);
      check_field("day_of_year", p.secs, p.cal.day_of_year, got.day_of_year);
    endfunction

    function int unsigned pending();
      return dates_q.size();
    endfunction
  endclass

  // ------------------------------------------------------------------
  // clock, reset, channels and the block
  // ------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  esc_in_if  stamp_if ();
  esc_out_if cal_if ();

  epoch_seconds_to_calendar DUT (
    .clk      (clk),
    .rst      (rst),
    .stamp    (stamp_if),
    .calendar (cal_if)
  );

  calendar_scoreboard sb = new();

  int unsigned cycles;
  int unsigned n_directed;
  bit          rx_gaps;    // receiver stalls at random while set
  bit          long_hold;  // one-shot request for a long receiver hold-off

  // both channels are sampled on the rising edge; drivers only move on the falling one
  always @(posedge clk) begin
    cal_t got;
    if (!rst) begin
      if (stamp_if.valid && stamp_if.ready) begin
        sb.note_stamp(stamp_if.seconds);
      end
      if (cal_if.valid && cal_if.ready) begin
        got.year_since_1900 = cal_if.year_since_1900;
        got.month           = cal_if.month;
        got.day_of_month    = cal_if.day_of_month;
        got.hour            = cal_if.hour;
        got.minute          = cal_if.minute;
        got.second          = cal_if.second;
        got.weekday         = cal_if.weekday;
        got.day_of_year     = cal_if.day_of_year;
        sb.check_result(got);
      end
    end
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, sb.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------

  // idle length: mostly short, now and then a long gap
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // seconds count for a given year offset, day of year and second of day,
  // clipped to the 32-bit range
  function automatic logic [31:0] stamp_at(int unsigned years, int unsigned yday,
                                           int unsigned sod);
    longint unsigned t;
    int unsigned     y;
    t = 0;
    for (y = 0; y < years; y++) begin
      t += (y[1:0] == LEAP_PHASE) ? YEAR_LEAP_SECS : YEAR_SECS;
    end
    t += longint'(yday) * DAY_SECS + sod;
    if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
    return t[31:0];
  endfunction

  // random stamp: mostly uniform over 32 bits, the rest aimed at year and
  // month edges, the first years and the top of the range
  function automatic logic [31:0] rand_stamp();
    int unsigned yday;
    int unsigned sod;
    case ($urandom_range(0, 9))
      6, 7: begin
        case ($urandom_range(0, 7))
          0: yday = 0;
          1: yday = 30;   // jan 31
          2: yday = 58;   // feb 28
          3: yday = 59;   // feb 29 or mar 1
          4: yday = 60;
          5: yday = 364;
          6: yday = 365;  // dec 31 of a leap year
          default: yday = $urandom_range(0, 365);
        endcase
        case ($urandom_range(0, 2))
          0: sod = 0;
          1: sod = DAY_SECS - 1;
          default: sod = $urandom_range(0, DAY_SECS - 1);
        endcase
        return stamp_at($urandom_range(0, LAST_YEAR), yday, sod);
      end
      8: return $urandom_range(0, 3 * YEAR_LEAP_SECS);
      9: return 32'hFFFF_FFFF - $urandom_range(0, YEAR_LEAP_SECS);
      default: return $urandom;
    endcase
  endfunction

  // offer one stamp from the next falling edge until it is taken
  task automatic send_stamp(input logic [31:0] secs);
    @(negedge clk);
    stamp_if.valid   <= 1'b1;
    stamp_if.seconds <= secs;
    do @(posedge clk); while (!stamp_if.ready);
  endtask

  // drop valid with junk on the payload meanwhile; n sets the length of the gap
  task automatic tx_idle(input int unsigned n);
    if (n == 0) return;
    @(negedge clk);
    stamp_if.valid   <= 1'b0;
    stamp_if.seconds <= $urandom;
    repeat (n - 1) @(negedge clk);
  endtask

  // sender pause: idle until every result is back, then past the longest latency
  task automatic drain();
    @(negedge clk);
    stamp_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_random(input int unsigned n, input bit tx_on, input bit rx_on);
    int unsigned i;
    rx_gaps = rx_on;
    for (i = 0; i < n; i++) begin
      send_stamp(rand_stamp());
      if (tx_on && $urandom_range(0, 2) == 0) tx_idle(gap_len());
    end
  endtask

  // ------------------------------------------------------------------
  // receiver: ready moves only on falling edges, one assignment per edge
  // ------------------------------------------------------------------
  initial begin
    cal_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        cal_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        cal_if.ready <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
        cal_if.ready <= 1'b0;
        repeat (gap_len()) @(negedge clk);
        cal_if.ready <= 1'b1;
      end else begin
        cal_if.ready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------
  initial begin
    logic [31:0] directed_q[$];
    stamp_if.valid   = 1'b0;
    stamp_if.seconds = '0;
    rx_gaps          = 1'b0;
    long_hold        = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: range ends, day and year edges, leap february and the
    // february after a leap year, the month search running into december
    directed_q = '{
      32'd0,                          // epoch, a monday
      32'd86399,                      // last second of the first day
      32'd86400,
      stamp_at(0, 364, DAY_SECS - 1), // last second of 1990
      stamp_at(1, 0, 0),
      stamp_at(2, 58, 0),             // feb 28 1992
      stamp_at(2, 59, 0),             // feb 29 1992
      stamp_at(2, 60, 0),             // mar 1 1992
      stamp_at(2, 365, DAY_SECS - 1), // dec 31 1992, day of year 365
      stamp_at(3, 0, 0),
      stamp_at(3, 58, 43200),         // feb 28 1993, noon
      stamp_at(3, 59, 0),             // mar 1 1993: february back to 28 days
      stamp_at(3, 334, 0),            // dec 1
      stamp_at(10, 180, 45296),       // mid year, 12:34:56
      stamp_at(LAST_YEAR, 0, 0) - 1,  // end of 2125
      stamp_at(LAST_YEAR, 0, 0),      // start of the last reachable year
      32'h8000_0000,
      32'h5555_5555,
      32'hAAAA_AAAA,
      32'hFFFF_FFFF                   // largest count, lands in 2126
    };
    rx_gaps = 1'b1;
    foreach (directed_q[i]) begin
      send_stamp(directed_q[i]);
      if (i % 3 == 2) tx_idle(gap_len());
    end
    n_directed = directed_q.size();
    drain();

    // random, both sides idling
    run_random(600, 1'b1, 1'b1);
    // random, no idling anywhere
    run_random(300, 1'b0, 1'b0);

    // backpressure: receiver holds off while the sender keeps offering,
    // so the output register and sequencer fill and stamp.ready stays low
    long_hold = 1'b1;
    run_random(8, 1'b0, 1'b0);
    drain();

    // random, only the sender idles, then only the receiver stalls
    run_random(600, 1'b1, 1'b0);
    run_random(450, 1'b0, 1'b1);

    drain();

    $display("converted %0d stamps (%0d directed), %0d results checked",
             sb.n_stamps, n_directed, sb.n_checked);
    $display("calendar years covered %0d..%0d, %0d field mismatches",
             sb.min_year + 1900, sb.max_year + 1900, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
